// ===== rtl/lzssd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzssd_pkg
// Shared types and constants of the LZSS stream decoder: history ring
// geometry, match length limits and the ring write request.
// ----------------------------------------------------------------------------
package lzssd_pkg;

  // History ring geometry
  localparam int RING_SIZE = 4096;
  localparam int RING_AW   = $clog2(RING_SIZE);
  localparam int FILL_W    = RING_AW + 1;

  // Match limits
  localparam int MAX_MATCH = 18;
  localparam int MIN_MATCH = 3;

  // Ring reset image: spaces below the start position, zeros from it upward
  localparam logic [RING_AW-1:0] RING_START = RING_AW'(RING_SIZE - MAX_MATCH);
  localparam logic [7:0]         PAD_BYTE   = 8'h20;
  localparam logic [7:0]         ZERO_BYTE  = 8'h00;

  // Ring write request
  typedef struct packed {
    logic               en;
    logic [RING_AW-1:0] addr;
    logic [7:0]         data;
  } ring_wr_t;

endpackage

// ===== rtl/lzssd_in_if.sv =====
// ----------------------------------------------------------------------------
// lzssd_in_if
// Compressed byte channel: valid/ready handshake with one byte per item.
// ----------------------------------------------------------------------------
interface lzssd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/lzssd_out_if.sv =====
// ----------------------------------------------------------------------------
// lzssd_out_if
// Decompressed byte channel: valid/ready handshake, one byte and two marks
// per item.
// ----------------------------------------------------------------------------
interface lzssd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;

  modport source (output valid, output out_byte, output run_last, output stream_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_done,
                  output ready);
endinterface

// ===== rtl/lzssd_ram.sv =====
// ----------------------------------------------------------------------------
// lzssd_ram
// Generic single-write, single-read RAM with registered read data.
// Read of an address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module lzssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lzssd_ring.sv =====
// ----------------------------------------------------------------------------
// lzssd_ring
// History ring: RAM plus a fill counter that stands in for the reset image,
// and same-cycle write forwarding for overlapping copies.
// ----------------------------------------------------------------------------
module lzssd_ring (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lzssd_pkg::RING_AW-1:0] rd_addr,
  input  lzssd_pkg::ring_wr_t       wr,
  output logic [7:0]                rd_data
);
  import lzssd_pkg::*;

  logic [7:0]         ram_q;
  logic [FILL_W-1:0]  fill;
  logic [RING_AW-1:0] rd_offset;
  logic               fwd_hit;
  logic [7:0]         fwd_data;
  logic               rd_written;
  logic [7:0]         rd_reset_val;

  lzssd_ram #(
    .WIDTH (8),
    .DEPTH (RING_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Writes run in order from the start position, so an entry has been
  // written exactly when its distance from the start is below the fill count
  assign rd_offset = rd_addr - RING_START;

  // Count written entries, saturating at the ring size
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr.en && fill != FILL_W'(RING_SIZE)) begin
      fill <= fill + FILL_W'(1);
    end
  end

  // Capture forwarding and reset-image selection alongside the RAM read
  always_ff @(posedge clk) begin
    fwd_hit      <= wr.en && (wr.addr == rd_addr);
    fwd_data     <= wr.data;
    rd_written   <= ({1'b0, rd_offset} < fill);
    rd_reset_val <= (rd_addr < RING_START) ? PAD_BYTE : ZERO_BYTE;
  end

  // Pick forwarded byte, stored byte or reset image
  always_comb begin
    if (fwd_hit) begin
      rd_data = fwd_data;
    end else if (rd_written) begin
      rd_data = ram_q;
    end else begin
      rd_data = rd_reset_val;
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(RING_SIZE))
    else $error("ring fill count beyond ring size");

  a_forward: assert property (@(posedge clk) disable iff (rst)
    (wr.en && wr.addr == rd_addr) |=> (rd_data == $past(wr.data)))
    else $error("same-cycle write not forwarded to read");

endmodule

// ===== rtl/lzss_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// lzss_stream_decoder
// LZSS decoder with a 4096-byte history ring: header skip, 16-bit output
// count, flag-governed literals and matches of 3 to 18 bytes.
// ----------------------------------------------------------------------------
// A literal leaves in the cycle after acceptance, or later while the output
// register stays full. The high byte of a match blocks input until the copy
// ends: one ring read to prime, then one byte per cycle while the output is
// not stalled. Reset is synchronous; the ring RAM is not cleared, a fill
// counter makes unwritten entries read as their reset image, so no clearing
// pass is run.
// ----------------------------------------------------------------------------
module lzss_stream_decoder (
  input logic         clk,
  input logic         rst,
  lzssd_in_if.sink    comp,
  lzssd_out_if.source decomp
);
  import lzssd_pkg::*;

  // Header phases
  localparam logic [2:0] PH_COUNT_LO = 3'd4;
  localparam logic [2:0] PH_COUNT_HI = 3'd5;
  localparam logic [2:0] PH_STREAM   = 3'd6;
  localparam logic [3:0] FLAG_TOKENS = 4'd8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIT,
    S_COPY
  } state_t;

  state_t             state;
  logic [2:0]         header_phase;
  logic [15:0]        bytes_remaining;
  logic [7:0]         token_flags;
  logic [3:0]         flags_left;
  logic [7:0]         match_low_byte;
  logic               awaiting_match_high;
  logic [RING_AW-1:0] write_position;
  logic [7:0]         lit_byte;
  logic [RING_AW-1:0] cur_addr;
  logic               rd_pend;
  logic [4:0]         run_left;

  logic               accept;
  logic               advance;
  logic               take_lit;
  logic               emit;
  logic               emit_last;
  logic [7:0]         emit_byte;
  logic [RING_AW-1:0] rd_addr;
  logic [7:0]         rd_data;
  ring_wr_t           ring_wr;

  assign comp.ready = (state == S_IDLE);
  assign accept     = comp.valid && comp.ready;
  assign advance    = !decomp.valid || decomp.ready;

  // Accepted byte is a literal token of the stream
  assign take_lit = accept && header_phase == PH_STREAM && bytes_remaining != 16'd0 &&
                    !awaiting_match_high && flags_left != 4'd0 && token_flags[0];

  // Select the byte leaving this cycle
  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_byte = comp.in_byte;
    unique case (state)
      S_IDLE: begin
        emit      = take_lit && advance;
        emit_last = 1'b1;
        emit_byte = comp.in_byte;
      end
      S_LIT: begin
        emit      = advance;
        emit_last = 1'b1;
        emit_byte = lit_byte;
      end
      S_COPY: begin
        emit      = rd_pend && advance;
        emit_last = (run_left == 5'd1) || (bytes_remaining == 16'd1);
        emit_byte = rd_data;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Next ring read: step on when the pending byte leaves, else re-read
  assign rd_addr = (state == S_COPY && rd_pend && advance) ? cur_addr + RING_AW'(1)
                                                           : cur_addr;

  // Every emitted byte also goes into the ring
  assign ring_wr.en   = emit;
  assign ring_wr.addr = write_position;
  assign ring_wr.data = emit_byte;

  lzssd_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .wr      (ring_wr),
    .rd_data (rd_data)
  );

  // Control state, token decode and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      header_phase        <= '0;
      bytes_remaining     <= '0;
      token_flags         <= '0;
      flags_left          <= '0;
      match_low_byte      <= '0;
      awaiting_match_high <= 1'b0;
      write_position      <= RING_START;
      rd_pend             <= 1'b0;
      run_left            <= '0;
      cur_addr            <= '0;
      decomp.valid        <= 1'b0;
    end else begin
      // Load a new output item, or drop the current one once taken
      if (emit) begin
        decomp.valid       <= 1'b1;
        decomp.out_byte    <= emit_byte;
        decomp.run_last    <= emit_last;
        decomp.stream_done <= (bytes_remaining == 16'd1);
        bytes_remaining    <= bytes_remaining - 16'd1;
        write_position     <= write_position + RING_AW'(1);
      end else if (decomp.ready) begin
        decomp.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (header_phase < PH_COUNT_LO) begin
              header_phase <= header_phase + 3'd1;
            end else if (header_phase == PH_COUNT_LO) begin
              bytes_remaining <= {8'h00, comp.in_byte};
              header_phase    <= PH_COUNT_HI;
            end else if (header_phase == PH_COUNT_HI) begin
              bytes_remaining[15:8] <= comp.in_byte;
              header_phase          <= PH_STREAM;
            end else if (bytes_remaining == 16'd0) begin
              // Stream complete: ignore further bytes
            end else if (awaiting_match_high) begin
              awaiting_match_high <= 1'b0;
              cur_addr <= {comp.in_byte[7:4], match_low_byte};
              run_left <= {1'b0, comp.in_byte[3:0]} + 5'(MIN_MATCH);
              rd_pend  <= 1'b0;
              state    <= S_COPY;
            end else if (flags_left == 4'd0) begin
              token_flags <= comp.in_byte;
              flags_left  <= FLAG_TOKENS;
            end else begin
              token_flags <= {1'b0, token_flags[7:1]};
              flags_left  <= flags_left - 4'd1;
              if (token_flags[0]) begin
                lit_byte <= comp.in_byte;
                if (!advance) begin
                  state <= S_LIT;
                end
              end else begin
                match_low_byte      <= comp.in_byte;
                awaiting_match_high <= 1'b1;
              end
            end
          end
        end
        S_LIT: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        S_COPY: begin
          cur_addr <= rd_addr;
          rd_pend  <= !(emit && emit_last);
          if (emit) begin
            run_left <= run_left - 5'd1;
            if (emit_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_copy_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |-> (bytes_remaining != 16'd0 && run_left != 5'd0))
    else $error("copy running with nothing left to emit");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    emit |=> (bytes_remaining == $past(bytes_remaining) - 16'd1))
    else $error("remaining count not stepped on emitted byte");

  a_wpos_step: assert property (@(posedge clk) disable iff (rst)
    emit |=> (write_position == $past(write_position) + RING_AW'(1)))
    else $error("write position not advanced on emitted byte");

  a_done_final: assert property (@(posedge clk) disable iff (rst)
    (emit && bytes_remaining == 16'd1) |=> (bytes_remaining == 16'd0 && state == S_IDLE))
    else $error("decoder not idle after final byte");

endmodule
